@@ rtl/row_layer_normalizer_unit_defines.svh @@
// Assertion macros shared by the row layer normalizer RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ROW_LAYER_NORMALIZER_UNIT_DEFINES_SVH
`define ROW_LAYER_NORMALIZER_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define RLN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define RLN_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/rlnorm_pkg.sv @@
// Types, constants and widths for the row layer normalizer.
// Used by every module of the block; depends on nothing.
package rlnorm_pkg;

    localparam int DATA_W       = 16;
    localparam int MAX_COLS_DEF = 64;
    localparam int LEN_W        = 7;
    localparam int EPS_W        = 16;
    localparam int SUM_W        = 23;
    localparam int SQ_W         = 32;
    localparam int ACC_W        = 39;
    localparam int DIVN_W       = 41;
    localparam int DIVD_W       = 25;
    localparam int VAR_W        = 33;
    localparam int V_W          = 34;
    localparam int RAD_W        = 50;
    localparam int ROOT_W       = 25;
    localparam int INV_W        = 33;

    localparam logic [LEN_W-1:0]  ROW_LEN_RST = 7'd64;
    localparam logic [EPS_W-1:0]  EPS_RST     = 16'd1;
    localparam logic [DIVN_W-1:0] INV_NUM     = 41'h100_0000_0000;

    localparam logic CFG_ROW_LENGTH = 1'b0;
    localparam logic CFG_EPSILON    = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_sample;
        logic signed [DATA_W-1:0] gamma_value;
        logic signed [DATA_W-1:0] beta_value;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] y_out;
        logic                     last_in_row;
    } t_out;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_VAR,
        DIV_INV
    } t_div_sel;

    typedef enum logic [4:0] {
        S_LOAD,
        S_MEAN,
        S_MEAN_W,
        S_SQ_RD,
        S_SQ_D,
        S_SQ_MUL,
        S_SQ_ACC,
        S_VAR,
        S_VAR_W,
        S_SQRT,
        S_SQRT_W,
        S_INV,
        S_INV_W,
        S_EM_RD,
        S_EM_D,
        S_EM_M1,
        S_EM_M2,
        S_EM_OUT
    } t_state;

    typedef struct packed {
        logic     accept_en;
        logic     load;
        logic     row_clr;
        logic     div_start;
        t_div_sel div_sel;
        logic     sqrt_start;
        logic     idx_clr;
        logic     idx_inc;
        logic     mem_rd;
        logic     d_en;
        logic     sq_en;
        logic     acc_en;
        logic     m1_en;
        logic     m2_en;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic last_load;
        logic div_done;
        logic sqrt_done;
        logic idx_last;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/rlnorm_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Uses rlnorm_pkg widths.
module rlnorm_div
    import rlnorm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVN_W-1:0] i_dividend,
    input  logic [DIVD_W-1:0] i_divisor,
    output logic              o_busy,
    output logic              o_done,
    output logic [DIVN_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIVN_W);
    localparam logic [CNT_W-1:0] LastStep = CNT_W'(DIVN_W - 1);

    logic [DIVN_W-1:0] r_q;
    logic [DIVD_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIVD_W:0]   w_trial;
    logic [DIVD_W:0]   w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_q[DIVN_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LastStep) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIVN_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIVD_W-1:0] : w_trial[DIVD_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ rtl/rlnorm_isqrt.sv @@
// Bit-serial integer square root of (value << 16), one result bit per cycle.
// Uses rlnorm_pkg widths.
module rlnorm_isqrt
    import rlnorm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [V_W-1:0]    i_value,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam int CNT_W = $clog2(ROOT_W);
    localparam logic [CNT_W-1:0] LastStep = CNT_W'(ROOT_W - 1);

    logic [RAD_W-1:0] r_a;
    logic [RAD_W-1:0] r_res;
    logic [RAD_W-1:0] r_bit;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [RAD_W:0]   w_sum;
    logic             w_ge;

    assign w_sum = {1'b0, r_res} + {1'b0, r_bit};
    assign w_ge  = {1'b0, r_a} >= w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LastStep) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= {i_value, 16'd0};
            r_res <= '0;
            r_bit <= RAD_W'(1) << (RAD_W - 2);
        end else if (r_busy) begin
            if (w_ge) begin
                r_a   <= r_a - w_sum[RAD_W-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

@@ rtl/rlnorm_ctrl.sv @@
// Sequencer for load, statistics and emit phases of the row normalizer.
// Uses rlnorm_pkg state, command and status types.
module rlnorm_ctrl
    import rlnorm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:   if (i_in_valid && i_sts.last_load) n_state = S_MEAN;
            S_MEAN:   n_state = S_MEAN_W;
            S_MEAN_W: if (i_sts.div_done) n_state = S_SQ_RD;
            S_SQ_RD:  n_state = S_SQ_D;
            S_SQ_D:   n_state = S_SQ_MUL;
            S_SQ_MUL: n_state = S_SQ_ACC;
            S_SQ_ACC: n_state = i_sts.idx_last ? S_VAR : S_SQ_RD;
            S_VAR:    n_state = S_VAR_W;
            S_VAR_W:  if (i_sts.div_done) n_state = S_SQRT;
            S_SQRT:   n_state = S_SQRT_W;
            S_SQRT_W: if (i_sts.sqrt_done) n_state = S_INV;
            S_INV:    n_state = S_INV_W;
            S_INV_W:  if (i_sts.div_done) n_state = S_EM_RD;
            S_EM_RD:  n_state = S_EM_D;
            S_EM_D:   n_state = S_EM_M1;
            S_EM_M1:  n_state = S_EM_M2;
            S_EM_M2:  n_state = S_EM_OUT;
            S_EM_OUT: begin
                if (i_sts.out_free) n_state = i_sts.idx_last ? S_LOAD : S_EM_RD;
            end
            default:  n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = DIV_MEAN;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.accept_en = 1'b1;
                o_cmd.load      = i_in_valid;
            end
            S_MEAN: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_MEAN;
                o_cmd.idx_clr   = 1'b1;
            end
            S_SQ_RD:  o_cmd.mem_rd = 1'b1;
            S_SQ_D:   o_cmd.d_en   = 1'b1;
            S_SQ_MUL: o_cmd.sq_en  = 1'b1;
            S_SQ_ACC: begin
                o_cmd.acc_en  = 1'b1;
                o_cmd.idx_inc = !i_sts.idx_last;
            end
            S_VAR: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_VAR;
            end
            S_SQRT: o_cmd.sqrt_start = 1'b1;
            S_INV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_INV;
                o_cmd.idx_clr   = 1'b1;
            end
            S_EM_RD: o_cmd.mem_rd = 1'b1;
            S_EM_D:  o_cmd.d_en   = 1'b1;
            S_EM_M1: o_cmd.m1_en  = 1'b1;
            S_EM_M2: o_cmd.m2_en  = 1'b1;
            S_EM_OUT: begin
                o_cmd.out_load = i_sts.out_free;
                o_cmd.idx_inc  = i_sts.out_free && !i_sts.idx_last;
                o_cmd.row_clr  = i_sts.out_free && i_sts.idx_last;
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/rlnorm_dp.sv @@
// Datapath: row store, running sum, statistics units, output register.
// Uses rlnorm_pkg, rlnorm_div, rlnorm_isqrt and the assertion macro header.
`include "row_layer_normalizer_unit_defines.svh"
module rlnorm_dp
    import rlnorm_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [EPS_W-1:0]  i_cfg_data,
    input  t_in               i_in_data,
    input  logic              i_out_stall,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic              o_out_valid,
    output t_out              o_out_data
);

    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_COLS);

    t_in                      mem [MAX_COLS];
    t_in                      r_rd;
    logic [LEN_W-1:0]         r_row_len;
    logic [EPS_W-1:0]         r_eps;
    logic [LEN_W-1:0]         r_count;
    logic signed [SUM_W-1:0]  r_sum;
    logic [AW-1:0]            r_idx;
    logic signed [DATA_W-1:0] r_mean;
    logic signed [DATA_W:0]   r_d;
    logic [SQ_W-1:0]          r_sq;
    logic [ACC_W-1:0]         r_acc;
    logic [VAR_W-1:0]         r_var;
    logic [ROOT_W-1:0]        r_root;
    logic [INV_W-1:0]         r_inv;
    logic signed [49:0]       r_p1;
    logic signed [41:0]       r_p2;
    t_div_sel                 r_div_sel;
    logic                     r_out_valid;
    t_out                     r_out;

    logic [LEN_W-1:0]         w_n;
    logic                     w_out_free;
    logic                     w_div_busy;
    logic                     w_div_done;
    logic [DIVN_W-1:0]        w_quot;
    logic [DIVN_W-1:0]        w_dividend;
    logic [DIVD_W-1:0]        w_divisor;
    logic [SUM_W-2:0]         w_abs_sum;
    logic                     w_sqrt_done;
    logic [ROOT_W-1:0]        w_root;
    logic [V_W-1:0]           w_v_raw;
    logic [V_W-1:0]           w_v;
    logic signed [INV_W:0]    w_inv_s;
    logic signed [50:0]       w_p1;
    logic signed [25:0]       w_nrm;
    logic signed [41:0]       w_p2;
    logic signed [34:0]       w_y;
    logic signed [DATA_W-1:0] w_y_sat;
    logic [DATA_W-1:0]        w_mean_mag;

    always_comb begin
        priority if (r_row_len == '0) begin
            w_n = LEN_W'(1);
        end else if (r_row_len > MaxLen) begin
            w_n = MaxLen;
        end else begin
            w_n = r_row_len;
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_len <= ROW_LEN_RST;
            r_eps     <= EPS_RST;
            r_count   <= '0;
            r_sum     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ROW_LENGTH: begin
                        r_row_len <= i_cfg_data[LEN_W-1:0];
                        r_count   <= '0;
                        r_sum     <= '0;
                    end
                    CFG_EPSILON: r_eps <= i_cfg_data;
                    default: ;
                endcase
            end else if (i_cmd.load) begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + SUM_W'(i_in_data.x_sample);
            end else if (i_cmd.row_clr) begin
                r_count <= '0;
                r_sum   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            mem[r_count[AW-1:0]] <= i_in_data;
        end
        if (i_cmd.mem_rd) begin
            r_rd <= mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    assign w_abs_sum = r_sum[SUM_W-1] ? (SUM_W-1)'(-r_sum) : r_sum[SUM_W-2:0];

    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_MEAN: begin
                w_dividend = DIVN_W'(w_abs_sum);
                w_divisor  = DIVD_W'(w_n);
            end
            DIV_VAR: begin
                w_dividend = DIVN_W'(r_acc);
                w_divisor  = DIVD_W'(w_n);
            end
            DIV_INV: begin
                w_dividend = INV_NUM;
                w_divisor  = r_root;
            end
            default: begin
                w_dividend = '0;
                w_divisor  = '0;
            end
        endcase
    end

    rlnorm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_mean_mag = w_quot[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_sel <= i_cmd.div_sel;
        end
        if (w_div_done) begin
            unique case (r_div_sel)
                DIV_MEAN: r_mean <= r_sum[SUM_W-1] ? DATA_W'(~w_mean_mag + 1'b1) : w_mean_mag;
                DIV_VAR:  r_var  <= w_quot[VAR_W-1:0];
                DIV_INV:  r_inv  <= w_quot[INV_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_v_raw = V_W'(r_var) + V_W'(r_eps);
    assign w_v     = (w_v_raw == '0) ? V_W'(1) : w_v_raw;

    rlnorm_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_value (w_v),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_sqrt_done) begin
            r_root <= (w_root == '0) ? ROOT_W'(1) : w_root;
        end
    end

    assign w_inv_s = {1'b0, r_inv};
    assign w_p1    = r_d * w_inv_s;
    assign w_nrm   = r_p1[49:24];
    assign w_p2    = w_nrm * r_rd.gamma_value;
    assign w_y     = 35'($signed(r_p2[41:8])) + 35'(r_rd.beta_value);

    always_comb begin
        priority if (w_y > 35'sd32767) begin
            w_y_sat = 16'sh7fff;
        end else if (w_y < -35'sd32768) begin
            w_y_sat = 16'sh8000;
        end else begin
            w_y_sat = w_y[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_clr && (i_cmd.div_sel == DIV_MEAN)) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en) begin
            r_acc <= r_acc + ACC_W'(r_sq);
        end
        if (i_cmd.d_en) begin
            r_d <= (DATA_W+1)'(r_rd.x_sample) - (DATA_W+1)'(r_mean);
        end
        if (i_cmd.sq_en) begin
            r_sq <= SQ_W'(r_d * r_d);
        end
        if (i_cmd.m1_en) begin
            r_p1 <= w_p1[49:0];
        end
        if (i_cmd.m2_en) begin
            r_p2 <= w_p2;
        end
        if (i_cmd.out_load) begin
            r_out.y_out       <= w_y_sat;
            r_out.last_in_row <= o_sts.idx_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.last_load = (r_count + 1'b1) >= w_n;
    assign o_sts.div_done  = w_div_done;
    assign o_sts.sqrt_done = w_sqrt_done;
    assign o_sts.idx_last  = (LEN_W'(r_idx) + 1'b1) == w_n;
    assign o_sts.out_free  = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `RLN_ASSERT(a_count_in_row, r_count <= w_n, "element count beyond row length")
    `RLN_ASSERT(a_out_load_free, i_cmd.out_load |-> w_out_free, "result overwritten while stalled")
    `RLN_ASSERT(a_div_start_idle, i_cmd.div_start |-> !w_div_busy, "divider restarted while busy")
    `RLN_ASSERT_ALWAYS(a_reset_out, !i_rst_n |=> !r_out_valid, "result valid after reset")

endmodule

@@ rtl/row_layer_normalizer_unit.sv @@
// Row layer normalizer: top level, joins the sequencer and the datapath.
// Uses rlnorm_pkg, rlnorm_ctrl and rlnorm_dp.
//
// Requests come in on i_in_valid / o_in_stall with i_in_data (sample, gamma,
// beta, signed Q8.8). Each accepted request is stored; the one that completes
// a row of row_length elements starts the statistics phase. Results leave on
// o_out_valid / i_out_stall with o_out_data (y_out, last_in_row set on the
// final element of the row). Configuration is written through i_cfg_we,
// i_cfg_idx and i_cfg_data while the block is idle; writing row_length drops
// any partial row.
// Processing of a row: loading accepts one element per cycle. Then the mean
// divide runs, then the squared-deviation pass reads, subtracts the mean,
// squares and accumulates each element, then the variance divide, the square
// root and the reciprocal divide run, all on one shared restoring divider and
// one bit-serial root unit. Each result then goes through the memory read, the
// deviation and two multiplier stages into the output register.
// o_in_stall is high from the end of a row until its last result is loaded
// into the output register. When the receiver stalls, the output register
// holds its result and the emit sequence waits. Reset (synchronous, active
// low) empties the output, clears the partial row and restores the config.
module row_layer_normalizer_unit
    import rlnorm_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [EPS_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    rlnorm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rlnorm_dp #(
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_in_stall = !w_cmd.accept_en;

endmodule
